// ----- rtl/c3zp_pkg.sv -----
// shared types and constants of the 3x3 zero-padded convolution filter
`default_nettype none

package c3zp_pkg;

  // geometry
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int GEOM_W    = 11;
  localparam int ROW_W     = GEOM_W + 1;

  // sample and coefficient widths
  localparam int PIX_W   = 8;
  localparam int COEF_W  = 16;
  localparam int KROW_W  = 3 * COEF_W;
  localparam int WORD_W  = 2 * PIX_W;
  localparam int PROD_W  = PIX_W + 1 + COEF_W;
  localparam int RSUM_W  = PROD_W + 2;
  localparam int SUM_W   = RSUM_W + 1;
  localparam int FRAC_W  = 8;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = KROW_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADD_OFFSET   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MID   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOT   = 3'd5;

  // reset values
  localparam logic [GEOM_W-1:0] IMAGE_WIDTH_RESET  = 11'd1024;
  localparam logic [GEOM_W-1:0] IMAGE_HEIGHT_RESET = 11'd1024;
  localparam logic [KROW_W-1:0] KERNEL_MID_RESET   = 48'd16777216;

  // 128.0 in signed Q19.8
  localparam logic signed [SUM_W-1:0] OFFSET_Q = 28'sd32768;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // output buffer
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
  localparam int FLIGHT_W   = 3;

  // border masks of one window
  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
  } mask_t;

  // per-item result control
  typedef struct packed {
    logic emit;
    logic last;
  } ctrl_t;

  // 3x3 window, [row][column], row 0 top, column 0 left
  typedef logic [2:0][2:0][PIX_W-1:0] pix_win_t;

  // three kernel rows, row 0 top
  typedef logic [2:0][KROW_W-1:0] kernel_t;

endpackage

`default_nettype wire

// ----- rtl/conv3x3_zero_pad_filter.sv -----
// top level of the 3x3 zero-padded convolution filter
//
//  channel   signals                                   direction
//  s_*       s_tvalid s_tready s_tdata s_tuser         pixels and padding ticks in
//  m_*       m_tvalid m_tready m_tdata m_tlast         filtered pixels out
//  cfg_*     cfg_valid cfg_ready cfg_index cfg_data    register writes
//
//  one item per clock while s_tready stays high; the edge that accepts a request reads
//  the line memory, then products, row sums, total and the output buffer write are
//  registered in turn before the result shows on m_tvalid.
//  reset clears control state only: line memory contents outside the current
//  plane are always masked by the border logic, so no clearing pass is run.
//  s_tready drops while requests in flight plus buffered results reach eight;
//  cfg is always ready.
`default_nettype none

module conv3x3_zero_pad_filter (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [c3zp_pkg::PIX_W-1:0]     s_tdata,   // [7:0] pixel
  input  wire logic                           s_tuser,   // [0] mode
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [c3zp_pkg::PIX_W-1:0]          m_tdata,   // [7:0] result_pixel
  output logic                                m_tlast,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [c3zp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [c3zp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import c3zp_pkg::*;

  // configuration registers
  logic [GEOM_W-1:0] image_width;
  logic [GEOM_W-1:0] image_height;
  logic              add_offset;
  kernel_t           kernel;

  // scan position
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;

  logic [GEOM_W-1:0] w_eff;
  logic [ROW_W-1:0]  h_eff;
  logic [ROW_W-1:0]  h_p1;
  logic              accept;
  logic              cfg_accept;
  logic              col_wrap;
  mask_t             mask;
  ctrl_t             ctrl;
  logic [PIX_W-1:0]  sample;

  logic              win_valid;
  pix_win_t          win;
  ctrl_t             win_ctrl;
  logic              sum_valid;
  logic signed [SUM_W-1:0] sum;
  ctrl_t             sum_ctrl;
  logic [PIX_W-1:0]  result;
  logic              push;
  logic              pop;
  logic [PIX_W:0]    out_data;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FLIGHT_W-1:0]   in_flight;

  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign accept     = s_tvalid && s_tready;

  // effective geometry
  always_comb begin
    if (image_width == '0) begin
      w_eff = GEOM_W'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w_eff = GEOM_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    h_eff = (image_height == '0) ? ROW_W'(1) : {1'b0, image_height};
    h_p1  = h_eff + ROW_W'(1);
  end

  // window center, borders and emit for the current position
  always_comb begin
    sample   = s_tuser ? '0 : s_tdata;
    col_wrap = (GEOM_W'(col) + GEOM_W'(1)) >= w_eff;
    if (col == '0) begin
      // center is the last column two rows up
      ctrl.emit  = (row >= ROW_W'(2)) && (row <= h_p1);
      ctrl.last  = (row == h_p1);
      mask.top   = (row == ROW_W'(2));
      mask.bot   = (row >= h_p1);
      mask.left  = (w_eff == GEOM_W'(1));
      mask.right = 1'b1;
    end else begin
      ctrl.emit  = (row >= ROW_W'(1)) && (row <= h_eff);
      ctrl.last  = 1'b0;
      mask.top   = (row == ROW_W'(1));
      mask.bot   = (row >= h_eff);
      mask.left  = (col == COL_W'(1));
      mask.right = 1'b0;
    end
  end

  // registers and scan counters
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RESET;
      image_height <= IMAGE_HEIGHT_RESET;
      add_offset   <= 1'b0;
      kernel[0]    <= '0;
      kernel[1]    <= KERNEL_MID_RESET;
      kernel[2]    <= '0;
      col          <= '0;
      row          <= '0;
    end else begin
      if (accept) begin
        if (ctrl.last) begin
          col <= '0;
          row <= '0;
        end else if (col_wrap) begin
          col <= '0;
          row <= row + ROW_W'(1);
        end else begin
          col <= col + COL_W'(1);
        end
      end
      if (cfg_accept) begin
        unique case (cfg_index)
          CFG_IMAGE_WIDTH: begin
            image_width <= cfg_data[GEOM_W-1:0];
            col         <= '0;
            row         <= '0;
          end
          CFG_IMAGE_HEIGHT: begin
            image_height <= cfg_data[GEOM_W-1:0];
            col          <= '0;
            row          <= '0;
          end
          CFG_ADD_OFFSET: add_offset <= cfg_data[0];
          CFG_KERNEL_TOP: kernel[0]  <= cfg_data[KROW_W-1:0];
          CFG_KERNEL_MID: kernel[1]  <= cfg_data[KROW_W-1:0];
          CFG_KERNEL_BOT: kernel[2]  <= cfg_data[KROW_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // line memory and window
  c3zp_line_mem u_line_mem (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_addr   (col),
    .in_sample (sample),
    .in_mask   (mask),
    .in_ctrl   (ctrl),
    .win_valid (win_valid),
    .win       (win),
    .win_ctrl  (win_ctrl)
  );

  // products and sum
  c3zp_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .win_valid  (win_valid),
    .win        (win),
    .win_ctrl   (win_ctrl),
    .kernel     (kernel),
    .add_offset (add_offset),
    .sum_valid  (sum_valid),
    .sum        (sum),
    .sum_ctrl   (sum_ctrl)
  );

  // truncate fraction and clamp to 0..255
  always_comb begin
    if (sum[SUM_W-1]) begin
      result = '0;
    end else if (|sum[SUM_W-2:FRAC_W+PIX_W]) begin
      result = PIX_MAX;
    end else begin
      result = sum[FRAC_W+PIX_W-1:FRAC_W];
    end
  end

  assign push = sum_valid && sum_ctrl.emit;
  assign pop  = m_tvalid && m_tready;

  c3zp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({sum_ctrl.last, result}),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_data  (out_data),
    .count     (fifo_count)
  );

  assign m_tdata = out_data[PIX_W-1:0];
  assign m_tlast = out_data[PIX_W];

  // requests inside the pipeline, counted against buffer room
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + FLIGHT_W'(accept) - FLIGHT_W'(sum_valid);
    end
  end

  assign s_tready =
    (FIFO_CNT_W'(fifo_count) + FIFO_CNT_W'(in_flight)) < FIFO_CNT_W'(FIFO_DEPTH);

endmodule

`default_nettype wire

// ----- rtl/c3zp_line_mem.sv -----
// line memory with read-modify-write, forwarding and window column registers
`default_nettype none

module c3zp_line_mem (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic [c3zp_pkg::COL_W-1:0] in_addr,
  input  wire logic [c3zp_pkg::PIX_W-1:0] in_sample,
  input  wire c3zp_pkg::mask_t          in_mask,
  input  wire c3zp_pkg::ctrl_t          in_ctrl,
  output logic                          win_valid,
  output c3zp_pkg::pix_win_t            win,
  output c3zp_pkg::ctrl_t               win_ctrl
);
  import c3zp_pkg::*;

  // each entry holds {row-2, row-1} samples of one column
  logic [WORD_W-1:0] mem [MAX_WIDTH];

  logic              s1_valid;
  logic [COL_W-1:0]  s1_addr;
  logic [PIX_W-1:0]  s1_sample;
  mask_t             s1_mask;
  ctrl_t             s1_ctrl;
  logic [WORD_W-1:0] rd_word;
  logic              fwd;
  logic [WORD_W-1:0] fwd_word;

  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] wr_word;
  logic [2:0][PIX_W-1:0] new_col;
  logic [2:0][PIX_W-1:0] col_a;
  logic [2:0][PIX_W-1:0] col_b;

  // read on request, forward a write to the same column in the same cycle
  always_ff @(posedge clk) begin
    if (in_valid) begin
      rd_word   <= mem[in_addr];
      fwd       <= s1_valid && (s1_addr == in_addr);
      fwd_word  <= wr_word;
      s1_addr   <= in_addr;
      s1_sample <= in_sample;
      s1_mask   <= in_mask;
      s1_ctrl   <= in_ctrl;
    end
    if (s1_valid) begin
      mem[s1_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  // modify: age the column by one row
  always_comb begin
    word    = fwd ? fwd_word : rd_word;
    wr_word = {word[PIX_W-1:0], s1_sample};
    new_col = {s1_sample, word[PIX_W-1:0], word[WORD_W-1:PIX_W]};
  end

  // two previous columns of the window
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      col_a <= col_b;
      col_b <= new_col;
    end
  end

  // window with zero padding at the borders
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && s1_mask.top) || (r == 2 && s1_mask.bot) ||
            (c == 0 && s1_mask.left) || (c == 2 && s1_mask.right)) begin
          win[r][c] = '0;
        end else if (c == 0) begin
          win[r][c] = col_a[r];
        end else if (c == 1) begin
          win[r][c] = col_b[r];
        end else begin
          win[r][c] = new_col[r];
        end
      end
    end
  end

  assign win_valid = s1_valid;
  assign win_ctrl  = s1_ctrl;

endmodule

`default_nettype wire

// ----- rtl/c3zp_mac.sv -----
// nine products and a registered adder tree with optional offset
`default_nettype none

module c3zp_mac (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       win_valid,
  input  wire c3zp_pkg::pix_win_t         win,
  input  wire c3zp_pkg::ctrl_t            win_ctrl,
  input  wire c3zp_pkg::kernel_t          kernel,
  input  wire logic                       add_offset,
  output logic                            sum_valid,
  output logic signed [c3zp_pkg::SUM_W-1:0] sum,
  output c3zp_pkg::ctrl_t                 sum_ctrl
);
  import c3zp_pkg::*;

  logic signed [PROD_W-1:0] prod [3][3];
  logic signed [RSUM_W-1:0] rsum [3];
  logic signed [SUM_W-1:0]  offset_add;
  logic  s2_valid;
  logic  s3_valid;
  ctrl_t s2_ctrl;
  ctrl_t s3_ctrl;

  // valid pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      s2_valid  <= win_valid;
      s3_valid  <= s2_valid;
      sum_valid <= s3_valid;
    end
  end

  // stage 2: nine parallel products
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[r][c] <= $signed({1'b0, win[r][c]}) *
                      $signed(kernel[r][c*COEF_W +: COEF_W]);
      end
    end
    s2_ctrl <= win_ctrl;
  end

  // stage 3: row sums
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      rsum[r] <= RSUM_W'(prod[r][0]) + RSUM_W'(prod[r][1]) + RSUM_W'(prod[r][2]);
    end
    s3_ctrl <= s2_ctrl;
  end

  assign offset_add = add_offset ? OFFSET_Q : SUM_W'(0);

  // stage 4: total plus offset
  always_ff @(posedge clk) begin
    sum      <= SUM_W'(rsum[0]) + SUM_W'(rsum[1]) + SUM_W'(rsum[2]) + offset_add;
    sum_ctrl <= s3_ctrl;
  end

endmodule

`default_nettype wire

// ----- rtl/c3zp_out_fifo.sv -----
// small result buffer between the pipeline and the output stream
`default_nettype none

module c3zp_out_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire logic [c3zp_pkg::PIX_W:0]      push_data,
  input  wire logic                          pop,
  output logic                               out_valid,
  output logic [c3zp_pkg::PIX_W:0]           out_data,
  output logic [c3zp_pkg::FIFO_CNT_W-1:0]    count
);
  import c3zp_pkg::*;

  logic [PIX_W:0]      buf_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  assign out_valid = (count != '0);
  assign out_data  = buf_q[rd_ptr];

endmodule

`default_nettype wire

// ----- verif/conv3x3_zero_pad_filter_tb.sv -----
// self-checking testbench of the 3x3 zero-padded convolution filter
`timescale 1ns / 100ps

localparam int HIST_DEPTH = 2 * c3zp_pkg::MAX_WIDTH + 3;
localparam int MISMATCH_REPORTS = 10;

// one expected output sample
typedef struct packed {
  logic [7:0] value;
  logic       last;
} filtered_pixel_t;

// shapes of kernel used by the random part
typedef enum int {
  KERNEL_RANDOM,
  KERNEL_SMALL,
  KERNEL_BLUR,
  KERNEL_IDENTITY,
  KERNEL_EDGE
} kernel_kind_t;

// tracks the filter state and the output samples still owed
class conv_board;
  logic [10:0]     width_set;
  logic [10:0]     height_set;
  logic            offset_on;
  logic [47:0]     kernel_rows [3];
  logic [7:0]      history [HIST_DEPTH];
  int              wr_ptr;
  int              col;
  int              row;
  filtered_pixel_t expected_pixels [$];
  int              failures;

  function new();
    width_set = c3zp_pkg::IMAGE_WIDTH_RESET;
    height_set = c3zp_pkg::IMAGE_HEIGHT_RESET;
    offset_on = 1'b0;
    kernel_rows[0] = '0;
    kernel_rows[1] = c3zp_pkg::KERNEL_MID_RESET;
    kernel_rows[2] = '0;
    foreach (history[i]) history[i] = '0;
    wr_ptr = 0;
    col = 0;
    row = 0;
    failures = 0;
  endfunction

  // register write; geometry restarts the plane
  function void write_reg(logic [2:0] index, logic [47:0] data);
    unique case (index)
      c3zp_pkg::CFG_IMAGE_WIDTH: begin
        width_set = data[10:0];
        col = 0;
        row = 0;
      end
      c3zp_pkg::CFG_IMAGE_HEIGHT: begin
        height_set = data[10:0];
        col = 0;
        row = 0;
      end
      c3zp_pkg::CFG_ADD_OFFSET: offset_on = data[0];
      c3zp_pkg::CFG_KERNEL_TOP: kernel_rows[0] = data;
      c3zp_pkg::CFG_KERNEL_MID: kernel_rows[1] = data;
      c3zp_pkg::CFG_KERNEL_BOT: kernel_rows[2] = data;
      default: ;
    endcase
  endfunction

  // accepted pixel or tick: store sample, finish the window it completes
  function void predict_pixel(logic mode, logic [7:0] pixel);
    int              w;
    int              h;
    int              crow;
    int              ccol;
    int              nr;
    int              nc;
    int              dr;
    int              dc;
    int              lag;
    int              idx;
    longint          acc;
    longint          sample_v;
    longint          coef_v;
    logic signed [15:0] coef;
    bit              emit;
    bit              last;
    filtered_pixel_t res;

    w = int'(width_set);
    if (w < 1) w = 1;
    if (w > c3zp_pkg::MAX_WIDTH) w = c3zp_pkg::MAX_WIDTH;
    h = int'(height_set);
    if (h < 1) h = 1;

    history[wr_ptr] = mode ? 8'd0 : pixel;

    // centre of the window completed by this item
    if (col >= 1) begin
      crow = row - 1;
      ccol = col - 1;
    end else begin
      crow = row - 2;
      ccol = w - 1;
    end
    emit = (crow >= 0) && (crow < h);
    last = 1'b0;
    acc = 0;

    if (emit) begin
      for (dr = 0; dr < 3; dr++) begin
        for (dc = 0; dc < 3; dc++) begin
          nr = crow + dr - 1;
          nc = ccol + dc - 1;
          // neighbours outside the image read as zero
          if (nr >= 0 && nr < h && nc >= 0 && nc < w) begin
            lag = 2 * w + 2 - dr * w - dc;
            idx = (wr_ptr + HIST_DEPTH - lag) % HIST_DEPTH;
            coef = kernel_rows[dr][16*dc +: 16];
            sample_v = longint'(history[idx]);
            coef_v = longint'(coef);
            acc += sample_v * coef_v;
          end
        end
      end
      if (offset_on) acc += 128 * 256;
      last = (crow == h - 1) && (ccol == w - 1);
    end

    // scan position of the next item
    wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
    if (last) begin
      col = 0;
      row = 0;
    end else if (col + 1 >= w) begin
      col = 0;
      row++;
    end else begin
      col++;
    end

    if (emit) begin
      // truncate the fraction, clamp to a byte
      if (acc < 0) res.value = 8'd0;
      else if ((acc >>> 8) > 255) res.value = 8'd255;
      else res.value = 8'(acc >>> 8);
      res.last = last;
      expected_pixels.push_back(res);
    end
  endfunction

  // accepted output sample against the oldest expectation
  function void check_result(logic [7:0] value, logic last);
    filtered_pixel_t want;
    if (expected_pixels.size() == 0) begin
      failures++;
      if (failures <= MISMATCH_REPORTS)
        $display("result with none expected: pixel %0d last %0b", value, last);
    end else begin
      want = expected_pixels.pop_front();
      if (value !== want.value || last !== want.last) begin
        failures++;
        if (failures <= MISMATCH_REPORTS)
          $display("result mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                   want.value, want.last, value, last);
      end
    end
  endfunction
endclass

module conv3x3_zero_pad_filter_tb;
  import c3zp_pkg::*;

  localparam int DRAIN_GAP = 12;
  localparam int RANDOM_ITEMS = 580;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic              clk;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [PIX_W-1:0]  s_tdata = '0;
  logic              s_tuser = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [PIX_W-1:0]  m_tdata;
  logic              m_tlast;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit          steady = 1'b0;
  int          stream_items = 0;
  logic [10:0] geom_w = IMAGE_WIDTH_RESET;
  logic [10:0] geom_h = IMAGE_HEIGHT_RESET;
  conv_board   board;

  conv3x3_zero_pad_filter dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // output side stalls
  always @(negedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= 33);
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata, m_tlast);
  end

  // one input request, with random gaps ahead of it
  task automatic send_item(input logic mode, input logic [7:0] pixel);
    while (!steady && $urandom_range(0, 99) < 33) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= pixel;
    do @(posedge clk); while (!s_tready);
    board.predict_pixel(mode, pixel);
    stream_items++;
    @(negedge clk);
  endtask

  // stop sending until every owed result is out
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (board.expected_pixels.size() != 0);
  endtask

  // also let result-free items leave the pipeline
  task automatic wait_drained();
    hold_until_drained();
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(index, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // geometry write, sometimes with stray upper bits
  task automatic set_geometry(input logic [10:0] w_set, input logic [10:0] h_set);
    logic [CFG_DATA_W-1:0] junk;
    junk = 48'({$urandom, $urandom});
    if ($urandom_range(0, 3) != 0) junk = '0;
    wait_drained();
    write_reg(CFG_IMAGE_WIDTH, {junk[47:11], w_set});
    write_reg(CFG_IMAGE_HEIGHT, {junk[47:11], h_set});
    geom_w = w_set;
    geom_h = h_set;
  endtask

  task automatic set_kernels(input kernel_kind_t kind);
    logic [15:0]           c [9];
    logic                  offset;
    logic [CFG_DATA_W-1:0] junk;
    junk = 48'({$urandom, $urandom});
    offset = 1'($urandom_range(0, 1));
    foreach (c[i]) begin
      unique case (kind)
        KERNEL_RANDOM:   c[i] = 16'($urandom);
        KERNEL_SMALL:    c[i] = 16'($urandom_range(0, 1023)) - 16'd512;
        KERNEL_BLUR:     c[i] = 16'h001C;
        KERNEL_IDENTITY: c[i] = 16'h0000;
        default:         c[i] = 16'hFF00;
      endcase
    end
    if (kind == KERNEL_IDENTITY) c[4] = 16'h0100;
    if (kind == KERNEL_EDGE) c[4] = 16'h0800;
    if (kind == KERNEL_BLUR || kind == KERNEL_IDENTITY) offset = 1'b0;
    if (kind == KERNEL_EDGE) offset = 1'b1;
    wait_drained();
    write_reg(CFG_ADD_OFFSET, {junk[47:1], offset});
    write_reg(CFG_KERNEL_TOP, {c[2], c[1], c[0]});
    write_reg(CFG_KERNEL_MID, {c[5], c[4], c[3]});
    write_reg(CFG_KERNEL_BOT, {c[8], c[7], c[6]});
    // indexes past the list are ignored
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, junk);
  endtask

  function automatic logic [7:0] rand_pixel();
    unique case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // one plane plus its drain ticks, sometimes cut short or paused
  task automatic run_frame(input logic [10:0] w_set, input logic [10:0] h_set,
                           input int noise_pct);
    int w;
    int h;
    int total;
    int stop_at;
    int pause_at;
    w = int'(w_set);
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = int'(h_set);
    if (h < 1) h = 1;
    total = w * h + w + 1;
    stop_at = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, total)) : total;
    pause_at = ($urandom_range(0, 5) == 0) ? int'($urandom_range(1, total)) : -1;
    if (w_set != geom_w || h_set != geom_h || $urandom_range(0, 3) == 0)
      set_geometry(w_set, h_set);
    for (int i = 0; i < stop_at; i++) begin
      if (i == pause_at) hold_until_drained();
      if (i < w * h)
        send_item($urandom_range(0, 99) < noise_pct, rand_pixel());
      else
        send_item($urandom_range(0, 99) >= noise_pct, rand_pixel());
    end
  endtask

  initial begin
    int          frame;
    int          goal;
    logic [10:0] w_pick;
    logic [10:0] h_pick;

    board = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset kernel (identity) on a 3x3 plane: extremes, tick inside, pixel in drain
    set_geometry(11'd3, 11'd3);
    send_item(1'b0, 8'd255);
    send_item(1'b0, 8'd0);
    send_item(1'b0, 8'd255);
    send_item(1'b1, 8'h5A);
    send_item(1'b0, 8'd128);
    send_item(1'b0, 8'd0);
    send_item(1'b0, 8'd255);
    send_item(1'b0, 8'd255);
    send_item(1'b0, 8'd1);
    send_item(1'b1, 8'd0);
    send_item(1'b0, 8'd200);
    send_item(1'b1, 8'hFF);
    send_item(1'b1, 8'd0);

    // extreme coefficients with offset, zero geometry used as 1x1
    wait_drained();
    write_reg(CFG_ADD_OFFSET, 48'd1);
    write_reg(CFG_KERNEL_TOP, {16'h0001, 16'h7FFF, 16'h8000});
    write_reg(CFG_KERNEL_MID, {16'h8000, 16'h7FFF, 16'hFFFF});
    write_reg(CFG_KERNEL_BOT, {16'h7FFF, 16'h8000, 16'h0100});
    write_reg(CFG_SPARE_LO, {48{1'b1}});
    write_reg(CFG_SPARE_HI, {48{1'b1}});
    set_geometry(11'd0, 11'd0);
    send_item(1'b0, 8'd255);
    send_item(1'b1, 8'd0);
    send_item(1'b1, 8'd255);
    // next plane starts right after the last one
    send_item(1'b0, 8'd0);
    send_item(1'b1, 8'd17);
    send_item(1'b0, 8'd255);

    // random planes, mostly small, one stretch with no idling
    frame = 0;
    goal = stream_items + RANDOM_ITEMS;
    while (stream_items < goal) begin
      if (frame % 3 == 0) set_kernels(kernel_kind_t'($urandom_range(0, 4)));
      steady = (frame >= 4 && frame < 10);
      if ($urandom_range(0, 6) == 0) begin
        w_pick = 11'($urandom_range(13, 40));
        h_pick = 11'($urandom_range(1, 4));
      end else begin
        w_pick = 11'($urandom_range(1, 12));
        h_pick = 11'($urandom_range(1, 8));
      end
      if ($urandom_range(0, 19) == 0) w_pick = '0;
      if ($urandom_range(0, 19) == 0) h_pick = '0;
      run_frame(w_pick, h_pick, ($urandom_range(0, 2) == 0) ? 20 : 3);
      frame++;
    end
    steady = 1'b0;

    // a wider plane and a tall narrow one
    set_kernels(KERNEL_SMALL);
    run_frame(11'd64, 11'd2, 3);
    set_kernels(KERNEL_EDGE);
    run_frame(11'd1, 11'd60, 3);

    hold_until_drained();
    repeat (20) @(negedge clk);
    if (board.failures == 0 && board.expected_pixels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
